// File: sv/tpss_pkg.sv
`default_nettype none
package tpss_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int LH_BITS = 20;
  localparam int LAYER_BITS = 16;
  localparam int TRI_BITS = 24;
  localparam int ZP_BITS = LAYER_BITS + LH_BITS;
  localparam int LANES = 4;
  localparam logic [LH_BITS-1:0] LH_RESET = LH_BITS'(200000);
endpackage
`default_nettype wire

// File: sv/tpss_div_cell.sv
`default_nettype none
module tpss_div_cell #(
  parameter int W = tpss_pkg::COORD_BITS_DEF,
  parameter int PW = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [W:0]   in_rem [tpss_pkg::LANES],
  input  wire logic [W:0]   in_low [tpss_pkg::LANES],
  input  wire logic [W:0]   in_m   [tpss_pkg::LANES],
  input  wire logic [PW-1:0] in_pay,
  output logic              out_valid,
  output logic [W:0]        out_rem [tpss_pkg::LANES],
  output logic [W:0]        out_low [tpss_pkg::LANES],
  output logic [W:0]        out_m   [tpss_pkg::LANES],
  output logic [PW-1:0]     out_pay
);
  import tpss_pkg::*;

  logic [W+1:0] t   [LANES];
  logic         ge  [LANES];
  logic [W+1:0] dif [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      t[i] = {in_rem[i], in_low[i][W]};
      dif[i] = t[i] - {1'b0, in_m[i]};
      ge[i] = t[i] >= {1'b0, in_m[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        out_rem[i] <= ge[i] ? dif[i][W:0] : t[i][W:0];
        out_low[i] <= {in_low[i][W-1:0], ge[i]};
        out_m[i] <= in_m[i];
      end
      out_pay <= in_pay;
    end
  end
endmodule
`default_nettype wire

// File: sv/triangle_plane_slice_segment.sv
`default_nettype none
// Slices one triangle per transaction against the plane z = layer_number * layer_height
// and returns the cut segment with its triangle index, or nothing when the plane misses
// the triangle. Fully pipelined: one triangle per cycle while the output does not stall;
// it divides in COORD_BITS + 1 restoring divider cells (one quotient bit per cell,
// four end point coordinates in parallel). A stall on the output freezes the whole pipe.
// layer_height is written on the cfg channel, which is always ready.
module triangle_plane_slice_segment #(
  parameter int COORD_BITS = tpss_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [tpss_pkg::LH_BITS-1:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // ax ay az bx by bz cx cy cz layer_number tri_index, zero padded
  input  wire logic [((9*COORD_BITS+tpss_pkg::LAYER_BITS+tpss_pkg::TRI_BITS+7)/8)*8-1:0]
                    s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // seg_x1 seg_y1 seg_x2 seg_y2 seg_tri, zero padded
  output logic [((4*COORD_BITS+tpss_pkg::TRI_BITS+7)/8)*8-1:0] m_axis_tdata
);
  import tpss_pkg::*;

  localparam int W = COORD_BITS;
  localparam int EW = (W > ZP_BITS ? W : ZP_BITS) + 2;
  localparam int PW = LANES + LANES*W + TRI_BITS;
  localparam int OUT_W = ((4*W+TRI_BITS+7)/8)*8;

  logic [LH_BITS-1:0] layer_height;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_height <= LH_RESET;
    end else if (cfg_valid) begin
      layer_height <= cfg_data;
    end
  end

  // stage a: capture and plane height
  logic a_valid;
  logic [W-1:0] a_v [9];
  logic [ZP_BITS-1:0] a_zp;
  logic [TRI_BITS-1:0] a_tri;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) a_v[i] <= s_axis_tdata[i*W +: W];
      a_zp <= ZP_BITS'(s_axis_tdata[9*W +: LAYER_BITS]) * ZP_BITS'(layer_height);
      a_tri <= s_axis_tdata[9*W+LAYER_BITS +: TRI_BITS];
    end
  end

  // stage b: pivot choice and edge differences
  logic signed [EW-1:0] zs [3];
  logic signed [EW-1:0] zp_s;
  logic on [3];
  logic up [3];
  logic [1:0] cnt;
  logic in_span;
  logic [1:0] pa, pb, pc;
  logic signed [EW-1:0] ne [2];
  logic signed [EW-1:0] me [2];
  logic signed [W:0] de [LANES];
  logic [W:0] mag_d [LANES];
  logic [W:0] mag_n [2];
  logic [W:0] mag_m [2];
  logic flat [2];
  logic [W-1:0] vb [LANES];
  logic [W-1:0] va_x, va_y;
  logic [1:0] pe;

  always_comb begin
    for (int i = 0; i < 3; i++) zs[i] = EW'($signed(a_v[i*3+2]));
    zp_s = $signed({{(EW-ZP_BITS){1'b0}}, a_zp});
    cnt = '0;
    in_span = 1'b0;
    for (int i = 0; i < 3; i++) begin
      on[i] = zs[i] == zp_s;
      up[i] = zs[i] > zp_s;
      cnt = cnt + 2'(up[i]);
      if (!up[i]) in_span = 1'b1;
    end
    in_span = in_span && (up[0] || up[1] || up[2] || on[0] || on[1] || on[2]);
    pa = 2'd0;
    priority if (on[0] && on[1]) pa = 2'd2;
    else if (on[0] && on[2]) pa = 2'd1;
    else if (on[1] && on[2]) pa = 2'd0;
    else if (cnt == 2'd1) pa = up[0] ? 2'd0 : (up[1] ? 2'd1 : 2'd2);
    else if (cnt == 2'd2) pa = !up[0] ? 2'd0 : (!up[1] ? 2'd1 : 2'd2);
    else pa = on[0] ? 2'd0 : (on[1] ? 2'd1 : 2'd2);
    unique case (pa)
      2'd0: begin pb = 2'd1; pc = 2'd2; end
      2'd1: begin pb = 2'd2; pc = 2'd0; end
      default: begin pb = 2'd0; pc = 2'd1; end
    endcase
    va_x = a_v[4'(pa*3)];
    va_y = a_v[4'(pa*3+1)];
    for (int e = 0; e < 2; e++) begin
      pe = (e == 0) ? pb : pc;
      ne[e] = zp_s - zs[pe];
      me[e] = zs[pa] - zs[pe];
      flat[e] = me[e] == '0;
      mag_n[e] = ne[e][EW-1] ? (W+1)'(-ne[e]) : (W+1)'(ne[e]);
      mag_m[e] = flat[e] ? (W+1)'(1) : (me[e][EW-1] ? (W+1)'(-me[e]) : (W+1)'(me[e]));
      vb[2*e] = a_v[4'(pe*3)];
      vb[2*e+1] = a_v[4'(pe*3+1)];
      de[2*e] = $signed({va_x[W-1], va_x}) - $signed({vb[2*e][W-1], vb[2*e]});
      de[2*e+1] = $signed({va_y[W-1], va_y}) - $signed({vb[2*e+1][W-1], vb[2*e+1]});
    end
    for (int i = 0; i < LANES; i++) begin
      mag_d[i] = flat[i/2] ? '0 : (de[i][W] ? -de[i] : de[i]);
    end
  end

  logic b_valid;
  logic [W:0] b_d [LANES];
  logic [W:0] b_n [2];
  logic [W:0] b_m [2];
  logic [LANES-1:0] b_neg;
  logic [W-1:0] b_vb [LANES];
  logic [TRI_BITS-1:0] b_tri;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && in_span;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        b_d[i] <= mag_d[i];
        b_vb[i] <= vb[i];
        b_neg[i] <= de[i][W] ^ ne[i/2][EW-1] ^ me[i/2][EW-1];
      end
      for (int e = 0; e < 2; e++) begin
        b_n[e] <= mag_n[e];
        b_m[e] <= mag_m[e];
      end
      b_tri <= a_tri;
    end
  end

  // stage c: products
  logic [2*W+1:0] prod [LANES];
  logic [W:0] ch_rem [W+2][LANES];
  logic [W:0] ch_low [W+2][LANES];
  logic [W:0] ch_m   [W+2][LANES];
  logic [PW-1:0] ch_pay [W+2];
  logic ch_valid [W+2];

  always_comb begin
    for (int i = 0; i < LANES; i++) prod[i] = b_d[i] * b_n[i/2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid[0] <= 1'b0;
    end else if (adv) begin
      ch_valid[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        ch_rem[0][i] <= prod[i][2*W+1:W+1];
        ch_low[0][i] <= prod[i][W:0];
        ch_m[0][i] <= b_m[i/2];
      end
      ch_pay[0] <= {b_tri, b_vb[3], b_vb[2], b_vb[1], b_vb[0], b_neg};
    end
  end

  for (genvar k = 0; k <= W; k++) begin : g_cell
    tpss_div_cell #(.W(W), .PW(PW)) u_cell (
      .clk(clk),
      .rst(rst),
      .en(adv),
      .in_valid(ch_valid[k]),
      .in_rem(ch_rem[k]),
      .in_low(ch_low[k]),
      .in_m(ch_m[k]),
      .in_pay(ch_pay[k]),
      .out_valid(ch_valid[k+1]),
      .out_rem(ch_rem[k+1]),
      .out_low(ch_low[k+1]),
      .out_m(ch_m[k+1]),
      .out_pay(ch_pay[k+1])
    );
  end

  // output: apply sign and offset
  logic [W-1:0] res [LANES];
  logic [PW-1:0] fp;

  always_comb begin
    fp = ch_pay[W+1];
    for (int i = 0; i < LANES; i++) begin
      res[i] = fp[i] ? fp[LANES+i*W +: W] - ch_low[W+1][i][W-1:0]
                     : fp[LANES+i*W +: W] + ch_low[W+1][i][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= ch_valid[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= OUT_W'({fp[PW-1 -: TRI_BITS], res[3], res[2], res[1], res[0]});
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> a_valid)
    else $error("accepted transaction did not enter the pipe");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(b_valid) && $stable(ch_valid[0]))
    else $error("pipe moved during a stall");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && !a_valid)
    else $error("pipe not empty after reset");
`endif
endmodule
`default_nettype wire
